### src/jsr_pkg.sv
// Shared types, codes and header lookup tables for the joint-stereo rewriter.
// No dependencies; used by every other file of the block but jsr_if.sv.
package jsr_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned NumW       = 26;  // 144000 * 448 fits in 26 bits
  localparam int unsigned DenW       = 16;
  localparam int unsigned QuoW       = 13;
  localparam int unsigned CntW       = 4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_SYNC  = 3'd2;
  localparam logic [2:0] ST_BAD_HDR   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_HALTED    = 3'd5;

  localparam logic [1:0] KIND_TAG     = 2'd0;
  localparam logic [1:0] KIND_HDR     = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_TAIL    = 2'd3;

  localparam logic [1:0] REG_AUDIO_END = 2'd0;
  localparam logic [1:0] REG_TARGET    = 2'd1;
  localparam logic [1:0] REG_REWRITE   = 2'd2;

  // Classified input byte as it travels from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       sos;
    logic       is_i;      // 0x49
    logic       is_d;      // 0x44
    logic       is_3;      // 0x33
    logic       is_ff;
    logic       sync_hi;   // bits 7:5 all set
  } jsr_item_t;

  typedef logic [8:0] kbps_row_t [16];

  localparam kbps_row_t KbpsLow = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
                                    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160,
                                    9'd0};
  localparam kbps_row_t KbpsV2L1 = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
                                     9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192,
                                     9'd224, 9'd256, 9'd0};
  localparam kbps_row_t KbpsV1L3 = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80,
                                     9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224,
                                     9'd256, 9'd320, 9'd0};
  localparam kbps_row_t KbpsV1L2 = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
                                     9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256,
                                     9'd320, 9'd384, 9'd0};
  localparam kbps_row_t KbpsV1L1 = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192,
                                     9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384,
                                     9'd416, 9'd448, 9'd0};

  // ver and lay are the raw header codes; zero means reserved or free format.
  function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [1:0] lay,
                                             input logic [3:0] idx);
    logic [8:0] r;
    r = '0;
    if (ver == 2'd3) begin
      case (lay)
        2'd1:    r = KbpsV1L3[idx];
        2'd2:    r = KbpsV1L2[idx];
        2'd3:    r = KbpsV1L1[idx];
        default: r = '0;
      endcase
    end else if (ver == 2'd2 && lay == 2'd3) begin
      r = KbpsV2L1[idx];
    end else if (ver != 2'd1 && lay != 2'd0) begin
      r = KbpsLow[idx];
    end
    return r;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sidx);
    logic [15:0] r;
    r = '0;
    case ({ver, sidx})
      4'b00_00: r = 16'd11025;
      4'b00_01: r = 16'd12000;
      4'b00_10: r = 16'd8000;
      4'b10_00: r = 16'd22050;
      4'b10_01: r = 16'd24000;
      4'b10_10: r = 16'd16000;
      4'b11_00: r = 16'd44100;
      4'b11_01: r = 16'd48000;
      4'b11_10: r = 16'd32000;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/jsr_if.sv
// Valid/ready channel interfaces for source bytes and rewritten bytes.
// No dependencies.
interface jsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_stream;
  modport source (output valid, output data_byte, output start_of_stream, input ready);
  modport sink   (input valid, input data_byte, input start_of_stream, output ready);
endinterface

interface jsr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  byte_kind;
  logic [2:0]  status;
  logic [23:0] frame_number;
  modport source (output valid, output out_byte, output byte_kind, output status,
                  output frame_number, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input status,
                  input frame_number, output ready);
endinterface

### src/jsr_front.sv
// Front end: accepts source bytes, classifies them and queues them.
// Depends on jsr_pkg and jsr_in_if.
module jsr_front import jsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  jsr_in_if.sink    in_ch,
  output logic      item_valid,
  output jsr_item_t item,
  input  logic      item_pop
);

  jsr_item_t          queue [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0]   fill;
  logic               push;
  logic               pop;
  jsr_item_t          cls;

  always_comb begin
    cls.data    = in_ch.data_byte;
    cls.sos     = in_ch.start_of_stream;
    cls.is_i    = (in_ch.data_byte == 8'h49);
    cls.is_d    = (in_ch.data_byte == 8'h44);
    cls.is_3    = (in_ch.data_byte == 8'h33);
    cls.is_ff   = (in_ch.data_byte == 8'hFF);
    cls.sync_hi = ((in_ch.data_byte & 8'hE0) == 8'hE0);
  end

  assign in_ch.ready = (fill != (QueueAw+1)'(QueueDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (fill != '0);
  assign pop         = item_pop && item_valid;
  assign item        = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end

endmodule

### src/jsr_div.sv
// Restoring divider, one quotient bit per cycle, for the frame length.
// Depends on jsr_pkg.
module jsr_div import jsr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [QuoW-1:0] quo
);

  localparam int unsigned WideW = DenW + QuoW;

  logic [NumW-1:0] rem;
  logic [DenW-1:0] dreg;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [WideW-1:0] trial;
  logic            take;

  assign trial = {{QuoW{1'b0}}, dreg} << cnt;
  assign take  = ({{(WideW-NumW){1'b0}}, rem} >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dreg <= den;
      quo  <= '0;
      cnt  <= CntW'(QuoW - 1);
    end else if (busy) begin
      if (take) begin
        rem      <= rem - trial[NumW-1:0];
        quo[cnt] <= 1'b1;
      end
      cnt <= cnt - 1'b1;
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

endmodule

### src/jsr_parser.sv
// Back end: walks ID3 tag and frames, rewrites channel mode, drives results.
// Depends on jsr_pkg, jsr_out_if and jsr_div.
module jsr_parser import jsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  jsr_item_t  item,
  output logic       item_pop,
  input  logic [31:0] audio_end,
  input  logic [1:0] target_mode,
  input  logic       rewrite_en,
  jsr_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    PH_FIRST, PH_ID3HDR, PH_ID3BODY, PH_FHDR, PH_PAYLOAD, PH_TAIL, PH_HALT
  } phase_t;

  typedef enum logic {S_RUN, S_DIV} ctl_t;

  ctl_t         ctl;
  phase_t       phase, e_phase, n_phase;
  logic [31:0]  offset, e_offset;
  logic [27:0]  tag_left, e_tag, n_tag;
  logic [15:0]  hold, e_hold, n_hold;
  logic [11:0]  fbl, e_fbl, n_fbl;
  logic [23:0]  fcount, e_fcount, n_fcount;
  logic [2:0]   err, e_err, n_err;
  logic [7:0]   ob;
  logic [1:0]   kind;
  logic [2:0]   st;
  logic         past_end;
  logic [8:0]   kbps;
  logic [15:0]  rate;
  logic         need_div;
  logic         out_free;
  logic         commit;
  logic         div_start;
  logic         div_done;
  logic [QuoW-1:0] quo;
  logic [NumW-1:0] num;
  logic [27:0]  tag_shift;

  // Start of stream restarts everything for this byte.
  always_comb begin
    e_phase  = item.sos ? PH_FIRST : phase;
    e_offset = item.sos ? '0 : offset;
    e_tag    = item.sos ? '0 : tag_left;
    e_hold   = item.sos ? '0 : hold;
    e_fbl    = item.sos ? '0 : fbl;
    e_fcount = item.sos ? '0 : fcount;
    e_err    = item.sos ? '0 : err;
  end

  assign past_end  = (e_offset >= audio_end);
  assign kbps      = kbps_lookup(e_hold[12:11], e_hold[10:9], e_hold[7:4]);
  assign rate      = rate_lookup(e_hold[12:11], e_hold[3:2]);
  assign num       = NumW'(kbps) * NumW'(144000);
  assign need_div  = (e_err == ST_OK) && (e_phase == PH_FHDR) && !past_end
                     && (e_fbl[1:0] == 2'd3) && (kbps != '0) && (rate != '0);
  assign out_free  = !out_ch.valid || out_ch.ready;
  assign commit    = item_valid && out_free && ((ctl == S_RUN && !need_div)
                     || (ctl == S_DIV && div_done));
  assign div_start = (ctl == S_RUN) && item_valid && out_free && need_div;
  assign item_pop  = commit;
  assign tag_shift = {e_tag[20:0], item.data[6:0]};

  jsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (rate),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    logic       run_frame;
    logic [11:0] len;
    run_frame = 1'b0;
    len       = 12'(quo) + 12'(e_hold[1]);
    ob       = item.data;
    kind     = KIND_TAIL;
    st       = ST_OK;
    n_phase  = e_phase;
    n_tag    = e_tag;
    n_hold   = e_hold;
    n_fbl    = e_fbl;
    n_fcount = e_fcount;
    n_err    = e_err;
    if (e_err != ST_OK) begin
      st = ST_HALTED;
    end else begin
      unique case (e_phase)
        PH_FIRST: begin
          if (item.is_i) begin
            n_phase = PH_ID3HDR;
            n_tag   = '0;
            kind    = KIND_TAG;
          end else if (past_end) begin
            n_phase = PH_TAIL;
          end else if (item.is_ff) begin
            n_fbl     = '0;
            run_frame = 1'b1;
          end else begin
            n_err = ST_BAD_START;
          end
        end
        PH_ID3HDR: begin
          if ((e_offset == 32'd1 && !item.is_d) || (e_offset == 32'd2 && !item.is_3)) begin
            n_err = ST_BAD_START;
          end else begin
            kind = KIND_TAG;
            if (e_offset >= 32'd6) n_tag = tag_shift;
            if (e_offset >= 32'd9) begin
              n_fbl   = '0;
              n_phase = (n_tag == '0) ? PH_FHDR : PH_ID3BODY;
            end
          end
        end
        PH_ID3BODY: begin
          kind = KIND_TAG;
          if (e_tag <= 28'd1) begin
            n_tag   = '0;
            n_fbl   = '0;
            n_phase = PH_FHDR;
          end else begin
            n_tag = e_tag - 1'b1;
          end
        end
        PH_FHDR, PH_PAYLOAD: run_frame = 1'b1;
        default: kind = KIND_TAIL;
      endcase
      if (run_frame) begin
        if (past_end) begin
          if (e_phase != PH_PAYLOAD && n_fbl == '0) n_phase = PH_TAIL;
          else n_err = ST_TRUNC;
        end else if (e_phase == PH_PAYLOAD) begin
          kind = KIND_PAYLOAD;
          if (e_fbl <= 12'd1) begin
            n_fbl   = '0;
            n_phase = PH_FHDR;
          end else begin
            n_fbl = e_fbl - 1'b1;
          end
        end else begin
          kind    = KIND_HDR;
          n_phase = PH_FHDR;
          case (n_fbl[1:0])
            2'd0: begin
              if (!item.is_ff) n_err = ST_BAD_SYNC;
              else begin
                if (e_fcount != '1) n_fcount = e_fcount + 1'b1;
                n_fbl = 12'd1;
              end
            end
            2'd1: begin
              if (!item.sync_hi) n_err = ST_BAD_SYNC;
              else begin
                n_hold = {item.data, 8'h00};
                n_fbl  = 12'd2;
              end
            end
            2'd2: begin
              n_hold = {e_hold[15:8], item.data};
              n_fbl  = 12'd3;
            end
            default: begin
              if (kbps == '0 || rate == '0) n_err = ST_BAD_HDR;
              else begin
                if (rewrite_en) ob = {target_mode, item.data[5:0]};
                n_fbl   = len - 12'd4;
                n_phase = PH_PAYLOAD;
              end
            end
          endcase
        end
      end
      // Fail: pass the byte as tail with the code, then halt.
      if (n_err != ST_OK) begin
        n_phase = PH_HALT;
        kind    = KIND_TAIL;
        st      = n_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ch.out_byte     <= ob;
      out_ch.byte_kind    <= kind;
      out_ch.status       <= st;
      out_ch.frame_number <= n_fcount;
    end
    if (rst) begin
      ctl          <= S_RUN;
      phase        <= PH_FIRST;
      offset       <= '0;
      fcount       <= '0;
      err          <= ST_OK;
      out_ch.valid <= 1'b0;
      tag_left     <= '0;
      hold         <= '0;
      fbl          <= '0;
    end else begin
      if (commit) begin
        phase        <= n_phase;
        offset       <= (e_offset == '1) ? e_offset : e_offset + 1'b1;
        fcount       <= n_fcount;
        err          <= n_err;
        tag_left     <= n_tag;
        hold         <= n_hold;
        fbl          <= n_fbl;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (ctl)
        S_RUN:   if (div_start) ctl <= S_DIV;
        S_DIV:   if (commit) ctl <= S_RUN;
        default: ctl <= S_RUN;
      endcase
    end
  end

endmodule

### src/mpeg_audio_joint_stereo_rewriter_top.sv
// Each byte is registered in the input queue, then in the output register; header
// byte 3 also waits for the bit-serial frame-length divider, and no further byte is
// taken until it is done. Throughput: one byte per cycle while the output is ready.
// Reset (rst, synchronous) clears the queue, parser state and config registers
// to audio_end all ones, joint stereo mode and rewriting on.
module mpeg_audio_joint_stereo_rewriter_top import jsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  jsr_in_if.sink      in_ch,
  jsr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] audio_end;
  logic [1:0]  target_mode;
  logic        rewrite_en;
  logic        item_valid;
  logic        item_pop;
  jsr_item_t   item;

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_end   <= '1;
      target_mode <= 2'd1;
      rewrite_en  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AUDIO_END: audio_end   <= cfg_data;
        REG_TARGET:    target_mode <= cfg_data[1:0];
        REG_REWRITE:   rewrite_en  <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  jsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  jsr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop),
    .audio_end   (audio_end),
    .target_mode (target_mode),
    .rewrite_en  (rewrite_en),
    .out_ch      (out_ch)
  );

endmodule

### bench/tb_mpeg_audio_joint_stereo_rewriter_top.sv
// Self-checking bench for the MPEG audio joint-stereo rewriter: directed table,
// then random ID3 tags and MPEG frame streams, checked against a built-in predictor.
// Depends on jsr_pkg and the channel interfaces in src/jsr_if.sv.
module tb_mpeg_audio_joint_stereo_rewriter_top;
  import jsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_ID3HDR  = 3'd1;
  localparam logic [2:0] PH_ID3BODY = 3'd2;
  localparam logic [2:0] PH_FHDR    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_TAIL    = 3'd5;
  localparam logic [2:0] PH_HALT    = 3'd6;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  kind;
    logic [2:0]  st;
    logic [23:0] frames;
  } rewritten_t;

  typedef struct {
    logic [7:0] data;
    logic       sos;
    bit         has_exp;  // typed-in expectation present
    logic [1:0] kind;
    logic [2:0] st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_AUDIO_END;
  logic [31:0] cfg_data = '0;

  jsr_in_if  in_ch ();
  jsr_out_if out_ch ();

  mpeg_audio_joint_stereo_rewriter_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state and copy of the registers
  logic [31:0] m_end;
  logic [1:0]  m_mode;
  logic        m_rw;
  logic [31:0] m_off;
  logic [2:0]  m_phase;
  logic [27:0] m_tag;
  logic [15:0] m_hold;
  logic [11:0] m_left;
  logic [23:0] m_frames;
  logic [2:0]  m_err;

  rewritten_t expected_bytes[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int bytes_checked = 0;
  int frames_seen = 0;
  bit idle_off = 1'b0;
  bit hold_off = 1'b0;

  function automatic int unsigned kbps_of(logic [1:0] ver, logic [1:0] lay, logic [3:0] idx);
    int unsigned lowt[16] = '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,160,0};
    int unsigned v2l1[16] = '{0,32,48,56,64,80,96,112,128,144,160,176,192,224,256,0};
    int unsigned v1l3[16] = '{0,32,40,48,56,64,80,96,112,128,160,192,224,256,320,0};
    int unsigned v1l2[16] = '{0,32,48,56,64,80,96,112,128,160,192,224,256,320,384,0};
    int unsigned v1l1[16] = '{0,32,64,96,128,160,192,224,256,288,320,352,384,416,448,0};
    if (lay == 2'd0 || ver == 2'd1) return 0;
    if (ver == 2'd3) return lay == 2'd1 ? v1l3[idx] : lay == 2'd2 ? v1l2[idx] : v1l1[idx];
    if (ver == 2'd2 && lay == 2'd3) return v2l1[idx];
    return lowt[idx];
  endfunction

  function automatic int unsigned rate_of(logic [1:0] ver, logic [1:0] sidx);
    int unsigned base;
    if (sidx == 2'd3 || ver == 2'd1) return 0;
    base = sidx == 2'd0 ? 44100 : sidx == 2'd1 ? 48000 : 32000;
    return ver == 2'd3 ? base : ver == 2'd2 ? base / 2 : base / 4;
  endfunction

  function automatic void model_restart();
    m_off = '0; m_phase = PH_FIRST; m_tag = '0; m_hold = '0;
    m_left = '0; m_frames = '0; m_err = ST_OK;
  endfunction

  function automatic void model_fail(logic [2:0] code, ref rewritten_t r);
    m_err = code; m_phase = PH_HALT; r.kind = KIND_TAIL; r.st = code;
  endfunction

  function automatic void model_frame_byte(logic [7:0] b, ref rewritten_t r);
    int unsigned br, sr, len;
    if (m_off >= m_end) begin
      if (m_phase == PH_FHDR && m_left == 0) begin
        m_phase = PH_TAIL; r.kind = KIND_TAIL;
      end else model_fail(ST_TRUNC, r);
      return;
    end
    if (m_phase == PH_PAYLOAD) begin
      r.kind = KIND_PAYLOAD;
      if (m_left <= 1) begin
        m_left = 0; m_phase = PH_FHDR;
      end else m_left--;
      return;
    end
    case (m_left[1:0])
      2'd0: begin
        if (b != 8'hFF) begin model_fail(ST_BAD_SYNC, r); return; end
        if (m_frames != 24'hFFFFFF) m_frames++;
        m_left = 1;
      end
      2'd1: begin
        if (b[7:5] != 3'b111) begin model_fail(ST_BAD_SYNC, r); return; end
        m_hold = {b, 8'h00}; m_left = 2;
      end
      2'd2: begin
        m_hold[7:0] = b; m_left = 3;
      end
      default: begin
        br = kbps_of(m_hold[12:11], m_hold[10:9], m_hold[7:4]) * 1000;
        sr = rate_of(m_hold[12:11], m_hold[3:2]);
        if (br == 0 || sr == 0) begin model_fail(ST_BAD_HDR, r); return; end
        len = 144 * br / sr + m_hold[1];
        if (m_rw) r.data = {m_mode, b[5:0]};
        m_left = 12'(len - 4);
        m_phase = PH_PAYLOAD;
        frames_seen++;
      end
    endcase
    r.kind = KIND_HDR;
  endfunction

  function automatic rewritten_t predict_byte(logic [7:0] b, logic sos);
    rewritten_t r;
    r = '{data: b, kind: KIND_TAIL, st: ST_OK, frames: '0};
    if (sos) model_restart();
    if (m_err != ST_OK) r.st = ST_HALTED;
    else begin
      case (m_phase)
        PH_FIRST: begin
          if (b == 8'h49) begin
            m_phase = PH_ID3HDR; m_tag = '0; r.kind = KIND_TAG;
          end else if (m_off >= m_end) m_phase = PH_TAIL;
          else if (b == 8'hFF) begin
            m_phase = PH_FHDR; m_left = 0; model_frame_byte(b, r);
          end else model_fail(ST_BAD_START, r);
        end
        PH_ID3HDR: begin
          if ((m_off == 1 && b != 8'h44) || (m_off == 2 && b != 8'h33))
            model_fail(ST_BAD_START, r);
          else begin
            r.kind = KIND_TAG;
            if (m_off >= 6) m_tag = {m_tag[20:0], b[6:0]};
            if (m_off >= 9) begin
              m_left = 0; m_phase = (m_tag == 0) ? PH_FHDR : PH_ID3BODY;
            end
          end
        end
        PH_ID3BODY: begin
          r.kind = KIND_TAG;
          if (m_tag <= 1) begin
            m_tag = 0; m_left = 0; m_phase = PH_FHDR;
          end else m_tag--;
        end
        PH_FHDR, PH_PAYLOAD: model_frame_byte(b, r);
        default: r.kind = KIND_TAIL;
      endcase
    end
    if (m_off != 32'hFFFFFFFF) m_off++;
    r.frames = m_frames;
    return r;
  endfunction

  // sender; valid stays up after the last transaction until the next idle or drain
  task automatic send_byte(logic [7:0] b, logic sos);
    while (!idle_off && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.start_of_stream <= sos;
    expected_bytes.push_back(predict_byte(b, sos));
    bytes_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_AUDIO_END: m_end = v;
      REG_TARGET:    m_mode = v[1:0];
      default:       m_rw = v[0];
    endcase
  endtask

  // one frame with random legal header and random payload; short frames mostly
  task automatic send_frame(bit first);
    logic [1:0] ver, lay, sidx;
    logic [3:0] idx;
    logic [7:0] b1, b2;
    int unsigned len;
    do begin
      ver = 2'($urandom); lay = 2'($urandom); sidx = 2'($urandom_range(2));
      idx = 4'($urandom_range(1, 14));
    end while (kbps_of(ver, lay, idx) == 0 || rate_of(ver, sidx) == 0
               || (144 * kbps_of(ver, lay, idx) * 1000 / rate_of(ver, sidx) > 120
                   && $urandom_range(19) != 0));
    b1 = {3'b111, ver, lay, 1'($urandom)};
    b2 = {idx, sidx, 1'($urandom), 1'($urandom)};
    len = 144 * kbps_of(ver, lay, idx) * 1000 / rate_of(ver, sidx) + b2[1];
    send_byte(8'hFF, first);
    send_byte(b1, 1'b0);
    send_byte(b2, 1'b0);
    send_byte(8'($urandom), 1'b0);
    for (int i = 4; i < len; i++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_stream(int unsigned nframes, bit with_tag);
    int unsigned tag_len;
    if (with_tag) begin
      tag_len = $urandom_range(0, 6);
      send_byte(8'h49, 1'b1); send_byte(8'h44, 1'b0); send_byte(8'h33, 1'b0);
      repeat (3) send_byte(8'($urandom), 1'b0);
      send_byte({1'($urandom), 7'h00}, 1'b0);
      send_byte({1'($urandom), 7'h00}, 1'b0);
      send_byte({1'($urandom), 7'h00}, 1'b0);
      send_byte({1'($urandom), 7'(tag_len)}, 1'b0);
      repeat (tag_len) send_byte(8'($urandom), 1'b0);
    end
    for (int f = 0; f < nframes; f++) send_frame(!with_tag && f == 0);
  endtask

  // receiver
  initial begin
    int long_hold;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        long_hold = 0;
        while (hold_off) begin
          @(posedge clk);
          long_hold++;
        end
      end else out_ch.ready <= idle_off || $urandom_range(99) >= 18;
    end
  end

  always @(posedge clk) begin
    rewritten_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.byte_kind, out_ch.status, out_ch.frame_number};
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output byte %h", got);
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch byte %0d: exp data %h kind %0d st %0d fr %0d, got %h %0d %0d %0d",
                     bytes_checked, want.data, want.kind, want.st, want.frames,
                     got.data, got.kind, got.st, got.frames);
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("*** FAILED ***");
    $finish;
  end

  stim_row_t table_rows[$];

  initial begin
    rewritten_t dir_exp;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.start_of_stream = 1'b0;
    m_end = 32'hFFFFFFFF; m_mode = 2'd1; m_rw = 1'b1;
    model_restart();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bad start without a start mark, then a halted byte
    table_rows.push_back('{8'h00, 1'b0, 1'b1, KIND_TAIL, ST_BAD_START});
    table_rows.push_back('{8'hFF, 1'b0, 1'b1, KIND_TAIL, ST_HALTED});
    // ID3 open with wrong second byte
    table_rows.push_back('{8'h49, 1'b1, 1'b1, KIND_TAG, ST_OK});
    table_rows.push_back('{8'h45, 1'b0, 1'b1, KIND_TAIL, ST_BAD_START});
    // wrong third byte
    table_rows.push_back('{8'h49, 1'b1, 1'b1, KIND_TAG, ST_OK});
    table_rows.push_back('{8'h44, 1'b0, 1'b1, KIND_TAG, ST_OK});
    table_rows.push_back('{8'h32, 1'b0, 1'b1, KIND_TAIL, ST_BAD_START});
    // bad second sync byte
    table_rows.push_back('{8'hFF, 1'b1, 1'b1, KIND_HDR, ST_OK});
    table_rows.push_back('{8'hDF, 1'b0, 1'b1, KIND_TAIL, ST_BAD_SYNC});
    // reserved version: bad header on byte 3
    table_rows.push_back('{8'hFF, 1'b1, 1'b1, KIND_HDR, ST_OK});
    table_rows.push_back('{8'hEB, 1'b0, 1'b1, KIND_HDR, ST_OK});
    table_rows.push_back('{8'h90, 1'b0, 1'b1, KIND_HDR, ST_OK});
    table_rows.push_back('{8'h00, 1'b0, 1'b1, KIND_TAIL, ST_BAD_HDR});
    // reserved bitrate index and reserved rate
    table_rows.push_back('{8'hFF, 1'b1, 1'b0, 0, 0});
    table_rows.push_back('{8'hFB, 1'b0, 1'b0, 0, 0});
    table_rows.push_back('{8'hF0, 1'b0, 1'b0, 0, 0});
    table_rows.push_back('{8'hFF, 1'b0, 1'b1, KIND_TAIL, ST_BAD_HDR});
    table_rows.push_back('{8'hFF, 1'b1, 1'b0, 0, 0});
    table_rows.push_back('{8'hFB, 1'b0, 1'b0, 0, 0});
    table_rows.push_back('{8'h9C, 1'b0, 1'b0, 0, 0});
    table_rows.push_back('{8'hC0, 1'b0, 1'b1, KIND_TAIL, ST_BAD_HDR});
    // good header, rewritten byte 3
    table_rows.push_back('{8'hFF, 1'b1, 1'b0, 0, 0});
    table_rows.push_back('{8'hFB, 1'b0, 1'b0, 0, 0});
    table_rows.push_back('{8'h92, 1'b0, 1'b0, 0, 0});
    table_rows.push_back('{8'hC4, 1'b0, 1'b0, 0, 0});
    foreach (table_rows[i]) begin
      dir_exp = predict_byte(table_rows[i].data, table_rows[i].sos);
      if (table_rows[i].has_exp &&
          (dir_exp.kind != table_rows[i].kind || dir_exp.st != table_rows[i].st)) begin
        mismatches++;
        $display("table row %0d: predictor kind %0d st %0d", i, dir_exp.kind, dir_exp.st);
      end
      expected_bytes.push_back(dir_exp);
      send_byte_raw(table_rows[i].data, table_rows[i].sos);
    end
    drain();

    // tail region: end of audio on a frame boundary, then in mid-frame
    write_reg(REG_AUDIO_END, 32'd0);
    send_byte(8'h12, 1'b1);
    repeat (4) send_byte(8'($urandom), 1'b0);
    send_byte(8'h49, 1'b1);
    repeat (3) send_byte(8'($urandom), 1'b0);
    drain();
    write_reg(REG_AUDIO_END, 32'd30);
    write_reg(REG_TARGET, 32'd3);
    send_stream(1, 1'b0);
    repeat (3) send_byte(8'($urandom), 1'b0);
    drain();

    // random phases through the register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_AUDIO_END, ph == 5 ? 32'hFFFFFFFF : $urandom_range(40, 400));
      write_reg(REG_TARGET, 32'(ph % 4));
      write_reg(REG_REWRITE, 32'(ph != 2));
      idle_off = (ph == 3);
      if (ph == 4) fork
        begin
          hold_off = 1'b1;
          repeat (60) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      // keep offering bytes while the receiver holds off
      if (ph == 4) send_stream(1, 1'b0);
      do begin
        case ($urandom_range(9))
          0: begin
            send_byte(8'($urandom), 1'b1);
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0);
          end
          1, 2: send_stream($urandom_range(1, 2), 1'b1);
          default: send_stream($urandom_range(1, 3), 1'b0);
        endcase
        // occasional corrupt byte inside a stream
        if ($urandom_range(5) == 0) send_byte(8'($urandom), 1'b0);
      end while (bytes_sent < 150 + ph * 45);
      idle_off = 1'b0;
      drain();
    end

    $display("sent %0d bytes, checked %0d, %0d frame headers parsed",
             bytes_sent, bytes_checked, frames_seen);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // drive one byte whose expectation is already queued
  task automatic send_byte_raw(logic [7:0] b, logic sos);
    while ($urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.start_of_stream <= sos;
    bytes_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

endmodule

### filelist.f
src/jsr_pkg.sv
src/jsr_if.sv
src/jsr_front.sv
src/jsr_div.sv
src/jsr_parser.sv
src/mpeg_audio_joint_stereo_rewriter_top.sv
bench/tb_mpeg_audio_joint_stereo_rewriter_top.sv
